// ===== hw/rtl/jacobi_heat_grid_solver_macros.svh =====
// Assertion macros used by the checker file of the grid solver.
`ifndef JACOBI_HEAT_GRID_SOLVER_MACROS_SVH
`define JACOBI_HEAT_GRID_SOLVER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define JHGS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define JHGS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/jhgs_pkg.sv =====
// ----------------------------------------------------------------------------
// jhgs_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package jhgs_pkg;

  localparam int unsigned MAX_DIM = 64;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM);
  localparam int unsigned ADDR_W  = 2 * DIM_W;
  localparam int unsigned CELLS   = MAX_DIM * MAX_DIM;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned ITER_W  = 16;
  localparam int unsigned ACC_W   = DATA_W + 2;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] KIND_CONVERGED = 2'd0;
  localparam logic [1:0] KIND_LIMIT     = 2'd1;
  localparam logic [1:0] KIND_SIZE_ERR  = 2'd2;
  localparam logic [1:0] KIND_READ      = 2'd3;

  localparam logic [1:0] REG_ROWS      = 2'd0;
  localparam logic [1:0] REG_COLS      = 2'd1;
  localparam logic [1:0] REG_MAX_ITER  = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  typedef struct packed {
    logic              rd_bank;
    logic [ADDR_W-1:0] rd_addr;
    logic              acc_clr;
    logic              acc_add;
    logic              ld_wr;
    logic              cell_wr;
    logic              wr_bank;
    logic [ADDR_W-1:0] wr_addr;
    logic              worst_clr;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] worst;
  } stat_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DATA_W-1:0] read_value;
    logic [ITER_W-1:0] iterations_done;
    logic [DATA_W-1:0] max_change;
  } res_t;

endpackage

// ===== hw/rtl/jacobi_heat_grid_solver.sv =====
// ----------------------------------------------------------------------------
// jacobi_heat_grid_solver
// Jacobi five-point Laplace solver over a 64 x 64 grid of Q16.16 cells.
// ----------------------------------------------------------------------------
// Load items (opcode 0) write one cell into both grid banks and give no
// result. Read items (opcode 2) return the cell of the current bank
// together with the statistics of the last run. A run item (opcode 1)
// sweeps the interior of the grid until the largest increase of a sweep
// is at most change_threshold or max_iterations sweeps are done. Every
// interior cell is handled in the steps N, S, W, E, C and WR, because its
// five reads (four neighbors and the old value) share the single read
// port of the source bank; a size error or a zero iteration limit answers
// at once. The block takes no item while a run or a read is in progress,
// or while a result waits at the output and is not being taken in that
// cycle. Cells that were never loaded hold undefined data. The user must
// write configuration through the cfg port only while the block is idle;
// the block itself does not enforce this.
module jacobi_heat_grid_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // row [5:0], col [11:6], cell_value [43:12], zero [47:44]
  input  logic [47:0] s_axis_tdata,
  // opcode [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_value [31:0], iterations_done [47:32], max_change [79:48]
  output logic [79:0] m_axis_tdata,
  // kind [1:0]
  output logic [1:0]  m_axis_tuser
);

  jhgs_pkg::cmd_t  cmd;
  jhgs_pkg::stat_t stat;
  jhgs_pkg::res_t  res;
  jhgs_pkg::res_t  out_q;
  logic            res_valid;
  logic            ready;
  logic            in_fire;
  logic            out_valid_q;
  logic            out_busy;

  // The output register holds one result; it counts as busy only when it
  // is full and the downstream side does not take it this cycle.
  assign out_busy      = out_valid_q && !m_axis_tready;
  assign s_axis_tready = ready;
  assign in_fire       = s_axis_tvalid && ready;

  jhgs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_fire_i   (in_fire),
    .opcode_i    (s_axis_tuser),
    .row_i       (s_axis_tdata[5:0]),
    .col_i       (s_axis_tdata[11:6]),
    .out_busy_i  (out_busy),
    .ready_o     (ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  jhgs_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .ld_data_i (s_axis_tdata[43:12]),
    .stat_o    (stat)
  );

  // A new result only appears when the register is empty or being drained,
  // which the controller guarantees by accepting items only then.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {out_q.max_change, out_q.iterations_done, out_q.read_value};

endmodule

// ===== hw/rtl/jhgs_datapath.sv =====
// ----------------------------------------------------------------------------
// jhgs_datapath
// Two grid banks, stencil accumulator and largest-increase tracker.
// ----------------------------------------------------------------------------
module jhgs_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  jhgs_pkg::cmd_t             cmd_i,
  input  logic [jhgs_pkg::DATA_W-1:0] ld_data_i,
  output jhgs_pkg::stat_t            stat_o
);

  logic [jhgs_pkg::DATA_W-1:0] mem_a [jhgs_pkg::CELLS];
  logic [jhgs_pkg::DATA_W-1:0] mem_b [jhgs_pkg::CELLS];
  logic [jhgs_pkg::DATA_W-1:0] rd_a_q, rd_b_q;
  logic                        rd_bank_q;
  logic [jhgs_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [jhgs_pkg::DATA_W-1:0] worst_q, worst_d;
  logic [jhgs_pkg::DATA_W-1:0] rdata, new_val, diff, wr_data;
  logic                        we_a, we_b;

  assign rdata   = rd_bank_q ? rd_b_q : rd_a_q;
  assign new_val = acc_q[jhgs_pkg::ACC_W-1:2];
  assign diff    = new_val - rdata;
  assign wr_data = cmd_i.ld_wr ? ld_data_i : new_val;
  assign we_a    = cmd_i.ld_wr | (cmd_i.cell_wr & ~cmd_i.wr_bank);
  assign we_b    = cmd_i.ld_wr | (cmd_i.cell_wr & cmd_i.wr_bank);

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[cmd_i.wr_addr] <= wr_data;
    end
    rd_a_q <= mem_a[cmd_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[cmd_i.wr_addr] <= wr_data;
    end
    rd_b_q <= mem_b[cmd_i.rd_addr];
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_clr) begin
      acc_d = '0;
    end else if (cmd_i.acc_add) begin
      acc_d = acc_q + {2'b00, rdata};
    end
    worst_d = worst_q;
    if (cmd_i.worst_clr) begin
      worst_d = '0;
    end else if (cmd_i.cell_wr && (new_val > rdata) && (diff > worst_q)) begin
      worst_d = diff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_bank_q <= 1'b0;
      worst_q   <= '0;
    end else begin
      rd_bank_q <= cmd_i.rd_bank;
      worst_q   <= worst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign stat_o.rdata = rdata;
  assign stat_o.worst = worst_q;

endmodule

// ===== hw/rtl/jhgs_ctrl.sv =====
// ----------------------------------------------------------------------------
// jhgs_ctrl
// Command sequencer: loads, reads and the sweep loop over the grid.
// ----------------------------------------------------------------------------
module jhgs_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [jhgs_pkg::DATA_W-1:0] cfg_data_i,
  input  logic                        in_fire_i,
  input  logic [1:0]                  opcode_i,
  input  logic [jhgs_pkg::DIM_W-1:0]  row_i,
  input  logic [jhgs_pkg::DIM_W-1:0]  col_i,
  input  logic                        out_busy_i,
  output logic                        ready_o,
  output logic                        res_valid_o,
  output jhgs_pkg::res_t              res_o,
  output jhgs_pkg::cmd_t              cmd_o,
  input  jhgs_pkg::stat_t             stat_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_CELL  = 3'd3;
  localparam logic [2:0] S_ENDS  = 3'd4;

  localparam logic [2:0] STEP_N = 3'd0;
  localparam logic [2:0] STEP_S = 3'd1;
  localparam logic [2:0] STEP_W = 3'd2;
  localparam logic [2:0] STEP_E = 3'd3;
  localparam logic [2:0] STEP_C = 3'd4;
  localparam logic [2:0] STEP_WR = 3'd5;

  localparam logic [jhgs_pkg::SIZE_W-1:0] DIM_MAX = jhgs_pkg::SIZE_W'(jhgs_pkg::MAX_DIM);

  logic [2:0]                  state_q, state_d;
  logic [2:0]                  step_q, step_d;
  logic [jhgs_pkg::DIM_W-1:0]  r_q, r_d, c_q, c_d;
  logic [jhgs_pkg::ITER_W-1:0] iter_q, iter_d;
  logic                        bank_q, bank_d;
  logic [jhgs_pkg::ITER_W-1:0] sweeps_q, sweeps_d;
  logic [jhgs_pkg::DATA_W-1:0] largest_q, largest_d;
  logic [jhgs_pkg::SIZE_W-1:0] rows_q, cols_q;
  logic [jhgs_pkg::ITER_W-1:0] max_iter_q;
  logic [jhgs_pkg::DATA_W-1:0] thr_q;
  logic [jhgs_pkg::SIZE_W-1:0] rows_c, cols_c;
  logic [jhgs_pkg::ITER_W-1:0] iter_next;
  logic [jhgs_pkg::DIM_W-1:0]  r_up, r_dn, c_up, c_dn;
  logic                        last_col, last_row, tiny;

  assign rows_c    = (rows_q > DIM_MAX) ? DIM_MAX : rows_q;
  assign cols_c    = (cols_q > DIM_MAX) ? DIM_MAX : cols_q;
  assign iter_next = iter_q + 1'b1;
  assign r_up      = r_q + 1'b1;
  assign r_dn      = r_q - 1'b1;
  assign c_up      = c_q + 1'b1;
  assign c_dn      = c_q - 1'b1;
  assign last_col  = ({1'b0, c_q} + 7'd2) == cols_c;
  assign last_row  = ({1'b0, r_q} + 7'd2) == rows_c;
  assign tiny      = (rows_c < 7'd3) || (cols_c < 7'd3);
  assign ready_o   = (state_q == S_IDLE) && !out_busy_i;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    r_d       = r_q;
    c_d       = c_q;
    iter_d    = iter_q;
    bank_d    = bank_q;
    sweeps_d  = sweeps_q;
    largest_d = largest_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    cmd_o           = '0;
    cmd_o.rd_bank   = bank_q;
    cmd_o.wr_bank   = ~bank_q;
    cmd_o.rd_addr   = {row_i, col_i};
    cmd_o.wr_addr   = {row_i, col_i};
    case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          case (opcode_i)
            jhgs_pkg::OP_LOAD: begin
              cmd_o.ld_wr = 1'b1;
            end
            jhgs_pkg::OP_RUN: begin
              sweeps_d  = '0;
              largest_d = '0;
              if ((rows_c < 7'd2) || (cols_c < 7'd2)) begin
                res_valid_o = 1'b1;
                res_o.kind  = jhgs_pkg::KIND_SIZE_ERR;
              end else if (max_iter_q == '0) begin
                res_valid_o = 1'b1;
                res_o.kind  = jhgs_pkg::KIND_LIMIT;
              end else begin
                iter_d  = '0;
                state_d = S_START;
              end
            end
            jhgs_pkg::OP_READ: begin
              state_d = S_READ;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_valid_o           = 1'b1;
        res_o.kind            = jhgs_pkg::KIND_READ;
        res_o.read_value      = stat_i.rdata;
        res_o.iterations_done = sweeps_q;
        res_o.max_change      = largest_q;
        state_d               = S_IDLE;
      end
      S_START: begin
        cmd_o.worst_clr = 1'b1;
        r_d    = jhgs_pkg::DIM_W'(1);
        c_d    = jhgs_pkg::DIM_W'(1);
        step_d = STEP_N;
        state_d = tiny ? S_ENDS : S_CELL;
      end
      S_CELL: begin
        step_d = step_q + 1'b1;
        case (step_q)
          STEP_N: begin
            cmd_o.rd_addr = {r_dn, c_q};
            cmd_o.acc_clr = 1'b1;
          end
          STEP_S: begin
            cmd_o.rd_addr = {r_up, c_q};
            cmd_o.acc_add = 1'b1;
          end
          STEP_W: begin
            cmd_o.rd_addr = {r_q, c_dn};
            cmd_o.acc_add = 1'b1;
          end
          STEP_E: begin
            cmd_o.rd_addr = {r_q, c_up};
            cmd_o.acc_add = 1'b1;
          end
          STEP_C: begin
            cmd_o.rd_addr = {r_q, c_q};
            cmd_o.acc_add = 1'b1;
          end
          STEP_WR: begin
            cmd_o.cell_wr = 1'b1;
            cmd_o.wr_addr = {r_q, c_q};
            step_d = STEP_N;
            if (last_col) begin
              c_d = jhgs_pkg::DIM_W'(1);
              if (last_row) begin
                state_d = S_ENDS;
              end else begin
                r_d = r_up;
              end
            end else begin
              c_d = c_up;
            end
          end
          default: begin
            step_d = STEP_N;
          end
        endcase
      end
      S_ENDS: begin
        bank_d    = ~bank_q;
        sweeps_d  = iter_next;
        largest_d = stat_i.worst;
        res_o.iterations_done = iter_next;
        res_o.max_change      = stat_i.worst;
        if (stat_i.worst <= thr_q) begin
          res_valid_o = 1'b1;
          res_o.kind  = jhgs_pkg::KIND_CONVERGED;
          state_d     = S_IDLE;
        end else if (iter_next == max_iter_q) begin
          res_valid_o = 1'b1;
          res_o.kind  = jhgs_pkg::KIND_LIMIT;
          state_d     = S_IDLE;
        end else begin
          iter_d  = iter_next;
          state_d = S_START;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      step_q     <= STEP_N;
      r_q        <= '0;
      c_q        <= '0;
      iter_q     <= '0;
      bank_q     <= 1'b0;
      sweeps_q   <= '0;
      largest_q  <= '0;
      rows_q     <= DIM_MAX;
      cols_q     <= DIM_MAX;
      max_iter_q <= jhgs_pkg::ITER_W'(1);
      thr_q      <= '0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      r_q       <= r_d;
      c_q       <= c_d;
      iter_q    <= iter_d;
      bank_q    <= bank_d;
      sweeps_q  <= sweeps_d;
      largest_q <= largest_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          jhgs_pkg::REG_ROWS:      rows_q     <= cfg_data_i[jhgs_pkg::SIZE_W-1:0];
          jhgs_pkg::REG_COLS:      cols_q     <= cfg_data_i[jhgs_pkg::SIZE_W-1:0];
          jhgs_pkg::REG_MAX_ITER:  max_iter_q <= cfg_data_i[jhgs_pkg::ITER_W-1:0];
          jhgs_pkg::REG_THRESHOLD: thr_q      <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/jhgs_checker.sv =====
// ----------------------------------------------------------------------------
// jhgs_checker
// Port-level checks of the grid solver, bound to the top level.
// ----------------------------------------------------------------------------
`include "jacobi_heat_grid_solver_macros.svh"

module jhgs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  `JHGS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `JHGS_ASSERT_NOW(a_size_err_zero, m_axis_tvalid && (m_axis_tuser == jhgs_pkg::KIND_SIZE_ERR), m_axis_tdata == '0, "size error result not all zero")
  `JHGS_ASSERT_NOW(a_conv_sweeps, m_axis_tvalid && (m_axis_tuser == jhgs_pkg::KIND_CONVERGED), (m_axis_tdata[47:32] != 16'd0) && (m_axis_tdata[31:0] == 32'd0), "converged result without sweeps")

endmodule

bind jacobi_heat_grid_solver jhgs_checker u_jhgs_checker (.*);
